/* hdl/value_search_block_cache_assert.svh */
// ----------------------------------------------------------------------------
// value_search_block_cache assertion macros
// Concurrent checks sampled on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef VALUE_SEARCH_BLOCK_CACHE_ASSERT_SVH
`define VALUE_SEARCH_BLOCK_CACHE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define VSBC_ASSERT_NOW(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define VSBC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

/* hdl/vsbc_pkg.sv */
// ----------------------------------------------------------------------------
// vsbc_pkg
// Shared types and constants of the value search block cache.
// ----------------------------------------------------------------------------
`default_nettype none

package vsbc_pkg;

  localparam int ADDR_W   = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int MATCH_W  = 5;
  localparam int SIDX_W   = 7;
  localparam int BLK_W    = 5;
  localparam int LINE_W   = 2;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_WRITE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FILL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MISS  = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CSCAN,
    S_SSCAN,
    S_FILL,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

/* hdl/value_search_block_cache.sv */
// ----------------------------------------------------------------------------
// value_search_block_cache
// Direct-mapped cache in front of a backing word store, searched by value.
//
//   channel  handshake            payload
//   input    in_valid / in_ready  action, address, value
//   output   out_valid/ out_ready status, cache_matches, store_index,
//                                 block_number, filled_line, replaced
//
// One item at a time. A search reads the line RAM one word a cycle; with no
// cache match it goes on to search the store RAM. The store RAM read port
// sets the miss time. After reset a clearing pass over all STORE_WORDS words
// clears the store valid bits; in_ready stays low meanwhile. A stalled result
// holds in the output register while the next item is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

`include "value_search_block_cache_assert.svh"

module value_search_block_cache #(
  parameter int STORE_WORDS = 128,
  parameter int BLOCK_WORDS = 4,
  parameter int CACHE_LINES = 4,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                action,
  input  wire logic        [vsbc_pkg::ADDR_W-1:0]  address,
  input  wire logic signed [vsbc_pkg::VALUE_W-1:0] value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [vsbc_pkg::STATUS_W-1:0] status,
  output logic             [vsbc_pkg::MATCH_W-1:0] cache_matches,
  output logic             [vsbc_pkg::SIDX_W-1:0]  store_index,
  output logic             [vsbc_pkg::BLK_W-1:0]   block_number,
  output logic             [vsbc_pkg::LINE_W-1:0]  filled_line,
  output logic                                     replaced
);

  localparam int LT    = CACHE_LINES * BLOCK_WORDS;
  localparam int SA_W  = $clog2(STORE_WORDS);
  localparam int LA_W  = $clog2(LT);
  localparam int LN_W  = $clog2(CACHE_LINES);
  localparam int BW_W  = $clog2(BLOCK_WORDS);
  localparam int MT_W  = $clog2(LT + 1);
  localparam int CNT_W = $clog2(((STORE_WORDS > LT) ? STORE_WORDS : LT) + 1);
  localparam int SRC_W = $clog2(STORE_WORDS + BLOCK_WORDS);

  vsbc_pkg::state_t state, state_next;

  logic [CNT_W-1:0]     cnt;
  logic [BW_W-1:0]      wc, wc_d;
  logic [LN_W-1:0]      lc, lc_d;
  logic [SA_W-1:0]      bc, bc_d;
  logic [SA_W-1:0]      idx_d;
  logic                 rd_v;
  logic                 inr_d;
  logic [WORD_BITS-1:0] item_val;
  logic [MT_W-1:0]      match_cnt;
  logic [CACHE_LINES-1:0] line_valid;

  logic [vsbc_pkg::STATUS_W-1:0] res_status;
  logic [SA_W-1:0]      res_sidx;
  logic [SA_W-1:0]      res_blk;
  logic [LN_W-1:0]      res_line;
  logic                 res_repl;
  logic [SA_W-1:0]      res_base;
  logic [LA_W-1:0]      res_lbase;

  logic                 s_we;
  logic [SA_W-1:0]      s_waddr, s_raddr;
  logic [WORD_BITS:0]   s_wdata, s_rdata;
  logic                 l_we;
  logic [LA_W-1:0]      l_waddr, l_raddr;
  logic [WORD_BITS-1:0] l_wdata, l_rdata;

  logic [WORD_BITS-1:0] in_val_w;
  logic                 in_fire;
  logic                 addr_ok;
  logic                 c_issue, s_issue, f_issue;
  logic                 c_hit, s_hit;
  logic [SRC_W-1:0]     fill_src;
  logic                 f_inr;

  vsbc_ram #(
    .WIDTH (WORD_BITS + 1),
    .DEPTH (STORE_WORDS)
  ) u_store_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  vsbc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LT)
  ) u_line_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  assign in_val_w = WORD_BITS'({{vsbc_pkg::VALUE_W{1'b0}}, value});
  assign in_fire  = in_valid && in_ready;
  assign addr_ok  = 32'(address) < 32'(STORE_WORDS);
  assign c_hit    = rd_v && line_valid[lc_d] && (l_rdata == item_val);
  assign s_hit    = rd_v && s_rdata[WORD_BITS] && (s_rdata[WORD_BITS-1:0] == item_val);
  assign c_issue  = cnt < CNT_W'(LT);
  assign s_issue  = (cnt < CNT_W'(STORE_WORDS)) && !s_hit;
  assign f_issue  = cnt < CNT_W'(BLOCK_WORDS);
  assign fill_src = SRC_W'(res_base) + SRC_W'(cnt);
  assign f_inr    = fill_src < SRC_W'(STORE_WORDS);

  always_comb begin
    state_next = state;
    case (state)
      vsbc_pkg::S_CLEAR: begin
        if (cnt == CNT_W'(STORE_WORDS - 1)) state_next = vsbc_pkg::S_IDLE;
      end
      vsbc_pkg::S_IDLE: begin
        if (in_fire) begin
          state_next = (action == vsbc_pkg::ACT_WRITE) ? vsbc_pkg::S_EMIT
                                                       : vsbc_pkg::S_CSCAN;
        end
      end
      vsbc_pkg::S_CSCAN: begin
        if (!c_issue && !rd_v) begin
          state_next = (match_cnt != '0) ? vsbc_pkg::S_EMIT : vsbc_pkg::S_SSCAN;
        end
      end
      vsbc_pkg::S_SSCAN: begin
        if (s_hit) state_next = vsbc_pkg::S_FILL;
        else if (!s_issue && !rd_v) state_next = vsbc_pkg::S_EMIT;
      end
      vsbc_pkg::S_FILL: begin
        if (!f_issue && !rd_v) state_next = vsbc_pkg::S_EMIT;
      end
      vsbc_pkg::S_EMIT: begin
        if (!out_valid || out_ready) state_next = vsbc_pkg::S_IDLE;
      end
      default: state_next = vsbc_pkg::S_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = (state == vsbc_pkg::S_IDLE);
    s_we     = 1'b0;
    s_waddr  = SA_W'(cnt);
    s_wdata  = '0;
    s_raddr  = (state == vsbc_pkg::S_FILL) ? SA_W'(fill_src) : SA_W'(cnt);
    l_we     = 1'b0;
    l_waddr  = res_lbase + LA_W'(wc_d);
    l_wdata  = (inr_d && s_rdata[WORD_BITS]) ? s_rdata[WORD_BITS-1:0] : '0;
    l_raddr  = LA_W'(cnt);
    case (state)
      vsbc_pkg::S_CLEAR: begin
        s_we = 1'b1;
      end
      vsbc_pkg::S_IDLE: begin
        s_we    = in_fire && (action == vsbc_pkg::ACT_WRITE) && addr_ok;
        s_waddr = SA_W'(address);
        s_wdata = {1'b1, in_val_w};
      end
      vsbc_pkg::S_FILL: begin
        l_we = rd_v;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= vsbc_pkg::S_CLEAR;
      cnt        <= '0;
      rd_v       <= 1'b0;
      line_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == vsbc_pkg::S_EMIT) && (state_next == vsbc_pkg::S_IDLE)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        vsbc_pkg::S_CLEAR: begin
          cnt <= (state_next == vsbc_pkg::S_IDLE) ? '0 : cnt + 1'b1;
        end
        vsbc_pkg::S_IDLE: begin
          if (in_fire) begin
            item_val   <= in_val_w;
            cnt        <= '0;
            wc         <= '0;
            lc         <= '0;
            bc         <= '0;
            rd_v       <= 1'b0;
            match_cnt  <= '0;
            res_status <= vsbc_pkg::ST_WRITE;
            res_sidx   <= '0;
            res_blk    <= '0;
            res_line   <= '0;
            res_repl   <= 1'b0;
          end
        end
        vsbc_pkg::S_CSCAN: begin
          rd_v <= c_issue;
          if (c_issue) begin
            cnt  <= cnt + 1'b1;
            lc_d <= lc;
            if (wc == BW_W'(BLOCK_WORDS - 1)) begin
              wc <= '0;
              lc <= (lc == LN_W'(CACHE_LINES - 1)) ? '0 : lc + 1'b1;
            end else begin
              wc <= wc + 1'b1;
            end
          end
          if (c_hit) match_cnt <= match_cnt + 1'b1;
          if (state_next == vsbc_pkg::S_EMIT) res_status <= vsbc_pkg::ST_HIT;
          if (state_next == vsbc_pkg::S_SSCAN) begin
            cnt <= '0;
            wc  <= '0;
            lc  <= '0;
            bc  <= '0;
          end
        end
        vsbc_pkg::S_SSCAN: begin
          rd_v <= s_issue;
          if (s_issue) begin
            cnt   <= cnt + 1'b1;
            idx_d <= SA_W'(cnt);
            wc_d  <= wc;
            lc_d  <= lc;
            bc_d  <= bc;
            if (wc == BW_W'(BLOCK_WORDS - 1)) begin
              wc <= '0;
              bc <= bc + 1'b1;
              lc <= (lc == LN_W'(CACHE_LINES - 1)) ? '0 : lc + 1'b1;
            end else begin
              wc <= wc + 1'b1;
            end
          end
          if (s_hit) begin
            res_status       <= vsbc_pkg::ST_FILL;
            res_sidx         <= idx_d;
            res_blk          <= bc_d;
            res_line         <= lc_d;
            res_repl         <= line_valid[lc_d];
            line_valid[lc_d] <= 1'b1;
            res_base         <= idx_d - SA_W'(wc_d);
            res_lbase        <= LA_W'(32'(lc_d) * BLOCK_WORDS);
            cnt              <= '0;
          end else if (state_next == vsbc_pkg::S_EMIT) begin
            res_status <= vsbc_pkg::ST_MISS;
          end
        end
        vsbc_pkg::S_FILL: begin
          rd_v <= f_issue;
          if (f_issue) begin
            cnt   <= cnt + 1'b1;
            wc_d  <= BW_W'(cnt);
            inr_d <= f_inr;
          end
        end
        vsbc_pkg::S_EMIT: begin
          if (state_next == vsbc_pkg::S_IDLE) begin
            status        <= res_status;
            cache_matches <= vsbc_pkg::MATCH_W'(match_cnt);
            store_index   <= vsbc_pkg::SIDX_W'(res_sidx);
            block_number  <= vsbc_pkg::BLK_W'(res_blk);
            filled_line   <= vsbc_pkg::LINE_W'(res_line);
            replaced      <= res_repl;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `VSBC_ASSERT_NOW(a_hit_count,
    (state == vsbc_pkg::S_EMIT && res_status == vsbc_pkg::ST_HIT),
    (match_cnt != '0), "hit reported with no matching cache word")
  `VSBC_ASSERT_NOW(a_miss_count,
    (state == vsbc_pkg::S_EMIT &&
     (res_status == vsbc_pkg::ST_FILL || res_status == vsbc_pkg::ST_MISS)),
    (match_cnt == '0), "store search after a cache match")
  `VSBC_ASSERT_NOW(a_fill_valid,
    (state == vsbc_pkg::S_EMIT && res_status == vsbc_pkg::ST_FILL),
    line_valid[res_line], "filled line not marked valid")
  `VSBC_ASSERT_NEXT(a_one_item, (in_valid && in_ready),
    (state != vsbc_pkg::S_IDLE), "second word taken while one is in flight")

endmodule

`default_nettype wire

/* hdl/vsbc_ram.sv */
// ----------------------------------------------------------------------------
// vsbc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module vsbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
